// ===== rtl/gcsd_pkg.sv =====
// gcsd_pkg: shared types, register codes and arithmetic helpers for the
// gnss cycle slip detector; no dependencies
`default_nettype none
package gcsd_pkg;

    localparam int VAL_W = 48;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_GF_THR = 2'd0;
    localparam logic [1:0] REG_MW_THR = 2'd1;
    localparam logic [1:0] REG_NFREQ  = 2'd2;

    localparam logic [VAL_W-1:0] MAX48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] MIN48 = 48'h8000_0000_0000;

    // write group from the sequencer to the history tables
    typedef struct packed {
        logic             we_gf;
        logic             we_mw;
        logic [VAL_W-1:0] gf;
        logic [VAL_W-1:0] mw;
    } t_hist_wr;

    // clamp a 128-bit two's complement value to 48 bits signed
    function automatic logic [VAL_W-1:0] sat48(input logic [127:0] v);
        logic [VAL_W-1:0] r;
        if (v[127:47] == {81{v[127]}}) begin
            r = v[47:0];
        end else if (v[127]) begin
            r = MIN48;
        end else begin
            r = MAX48;
        end
        return r;
    endfunction

    // previous value present and the jump exceeds the threshold
    function automatic logic jump_over(input logic [VAL_W-1:0] prev,
                                       input logic [VAL_W-1:0] now,
                                       input logic [31:0]      thr);
        logic [VAL_W:0] d;
        logic [VAL_W:0] a;
        d = {now[VAL_W-1], now} - {prev[VAL_W-1], prev};
        a = d[VAL_W] ? (~d + 49'd1) : d;
        return (prev != '0) && (a > {17'd0, thr});
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gnss_cycle_slip_detector_unit.sv =====
// gnss_cycle_slip_detector_unit: top level, sequencer around a shared multiplier and divider
// depends on gcsd_pkg, gcsd_mul, gcsd_div, gcsd_hist
`default_nettype none
// Cycle-slip detector for one satellite observation per transaction. Loss-of-lock
// bits flag single frequencies; the geometry-free (gf) and Melbourne-Wubbena (mw)
// combinations are compared with each satellite's previous values, and a jump
// above the programmed threshold flags all frequencies in use. The block handles
// one observation at a time and drops s_axis_tready while it works. When mw is
// formed as well as gf, the bit-serial divider runs two 128-step divisions, while
// the 13 partial products go through one 32x32 multiplier. After reset the history
// tables are swept to zero, one satellite per cycle, and no observation is taken
// until the sweep has cleared all MAX_SATS entries; configuration writes are taken
// at any time but belong to an idle block. Results wait in the output register
// until m_axis_tready.
module gnss_cycle_slip_detector_unit #(
    parameter int MAX_SATS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sat[7:0] lli_bits[13:8] phase_f1[77:14] phase_f2[141:78] phase_f3[205:142]
    // range_f1[253:206] range_second[301:254] wavelength_f1[333:302]
    // wavelength_second[365:334] zero[367:366]
    input  logic [367:0] s_axis_tdata,
    // second_is_f3[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sat_out[7:0] slip_mask[10:8] gf_value[58:11] mw_value[106:59] zero[111:107]
    output logic [111:0] m_axis_tdata,
    // gf_valid[0] mw_valid[1]
    output logic [1:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int AW = $clog2(MAX_SATS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_GF, ST_DIV, ST_DIVW, ST_OUT
    } t_state;

    // multiplier schedule: gf terms, lam1*lam2, t1 numerator, t2 numerator
    typedef enum logic [3:0] {
        OP_G1L, OP_G1H, OP_G2L, OP_G2H, OP_LL,
        OP_T1A, OP_T1B, OP_T1C, OP_T1D,
        OP_T2A, OP_T2B, OP_T2C, OP_T2D
    } t_op;

    t_state r_state;
    t_op    r_op;

    // configuration registers
    logic [31:0] r_gf_thr;
    logic [31:0] r_mw_thr;
    logic [1:0]  r_nfreq;

    // input fields
    logic [7:0]  w_sat;
    logic [5:0]  w_lli;
    logic [63:0] w_ph1, w_ph2, w_ph3, w_l2;
    logic [47:0] w_p1, w_p2;
    logic [31:0] w_lam1, w_lam2;
    logic        w_sel3;
    logic        w_in_acc;
    logic [2:0]  w_lli_mask;
    logic [64:0] w_dl;
    logic [3:0]  w_all;

    // per-item working registers
    logic [7:0]   r_sat;
    logic [2:0]   r_mask;
    logic [63:0]  r_m1, r_m2, r_dmag, r_ll;
    logic         r_neg1, r_neg2, r_dneg, r_wneg;
    logic [31:0]  r_lam1, r_lam2, r_wdiff;
    logic [47:0]  r_p1, r_p2;
    logic         r_gf_ok, r_mw_ok, r_in_table;
    logic [127:0] r_acc, r_t1;
    logic [127:0] n_acc;

    // result register
    logic         r_o_valid;
    logic [47:0]  r_o_gf, r_o_mw;
    logic         r_o_gfv, r_o_mwv;

    // shared units
    logic [31:0]  w_mul_a, w_mul_b;
    logic [1:0]   w_sh;
    logic         w_sub;
    logic [63:0]  w_prod;
    logic [127:0] w_term;
    logic         w_div_start;
    logic [63:0]  w_div_den;
    logic [127:0] w_quo;
    logic         w_div_done;

    // history
    logic [47:0]        w_prev_gf, w_prev_mw;
    logic               w_hist_ready;
    gcsd_pkg::t_hist_wr w_wr;
    logic [47:0]        w_gf, w_mw;
    logic               w_gfv, w_mwv, w_jgf, w_jmw;
    logic [127:0]       w_t1s;

    assign w_sat  = s_axis_tdata[7:0];
    assign w_lli  = s_axis_tdata[13:8];
    assign w_ph1  = s_axis_tdata[77:14];
    assign w_ph2  = s_axis_tdata[141:78];
    assign w_ph3  = s_axis_tdata[205:142];
    assign w_p1   = s_axis_tdata[253:206];
    assign w_p2   = s_axis_tdata[301:254];
    assign w_lam1 = s_axis_tdata[333:302];
    assign w_lam2 = s_axis_tdata[365:334];
    assign w_sel3 = s_axis_tuser[0];
    assign w_l2   = w_sel3 ? w_ph3 : w_ph2;

    assign s_axis_tready = (r_state == ST_IDLE) && w_hist_ready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // frequencies in use, as a mask
    assign w_all = (4'd1 << r_nfreq) - 4'd1;

    // loss-of-lock flags on frequencies in use with a phase present
    always_comb begin
        w_lli_mask[0] = (r_nfreq > 2'd0) && (w_ph1 != '0) && (w_lli[1:0] != 2'b00);
        w_lli_mask[1] = (r_nfreq > 2'd1) && (w_ph2 != '0) && (w_lli[3:2] != 2'b00);
        w_lli_mask[2] = (r_nfreq > 2'd2) && (w_ph3 != '0) && (w_lli[5:4] != 2'b00);
    end

    // phase difference for mw, one bit wider than the phases
    assign w_dl = {w_ph1[63], w_ph1} - {w_l2[63], w_l2};

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_sh    = 2'd0;
        w_sub   = 1'b0;
        case (r_op)
            OP_G1L: begin
                w_mul_a = r_lam1;  w_mul_b = r_m1[31:0];  w_sub = r_neg1;
            end
            OP_G1H: begin
                w_mul_a = r_lam1;  w_mul_b = r_m1[63:32]; w_sub = r_neg1;  w_sh = 2'd1;
            end
            OP_G2L: begin
                w_mul_a = r_lam2;  w_mul_b = r_m2[31:0];  w_sub = !r_neg2;
            end
            OP_G2H: begin
                w_mul_a = r_lam2;  w_mul_b = r_m2[63:32]; w_sub = !r_neg2; w_sh = 2'd1;
            end
            OP_LL: begin
                w_mul_a = r_lam1;  w_mul_b = r_lam2;
            end
            OP_T1A: begin
                w_mul_a = r_ll[31:0];  w_mul_b = r_dmag[31:0];
            end
            OP_T1B: begin
                w_mul_a = r_ll[31:0];  w_mul_b = r_dmag[63:32]; w_sh = 2'd1;
            end
            OP_T1C: begin
                w_mul_a = r_ll[63:32]; w_mul_b = r_dmag[31:0];  w_sh = 2'd1;
            end
            OP_T1D: begin
                w_mul_a = r_ll[63:32]; w_mul_b = r_dmag[63:32]; w_sh = 2'd2;
            end
            OP_T2A: begin
                w_mul_a = r_lam2;  w_mul_b = r_p1[31:0];
            end
            OP_T2B: begin
                w_mul_a = r_lam2;  w_mul_b = {16'd0, r_p1[47:32]}; w_sh = 2'd1;
            end
            OP_T2C: begin
                w_mul_a = r_lam1;  w_mul_b = r_p2[31:0];
            end
            OP_T2D: begin
                w_mul_a = r_lam1;  w_mul_b = {16'd0, r_p2[47:32]}; w_sh = 2'd1;
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    assign w_term = 128'(w_prod) << {w_sh, 5'd0};
    assign n_acc  = w_sub ? (r_acc - w_term) : (r_acc + w_term);

    // gf: product difference floored to q.16, then clamped
    assign w_gf  = gcsd_pkg::sat48({{32{r_acc[127]}}, r_acc[127:32]});
    assign w_gfv = r_gf_ok && (w_gf != '0);
    assign w_jgf = r_in_table && w_gfv && gcsd_pkg::jump_over(w_prev_gf, w_gf, r_gf_thr);

    // mw: t1 - t2 with t2 the quotient now leaving the divider
    assign w_t1s = (r_dneg ^ r_wneg) ? (~w_quo + 128'd1) : w_quo;
    assign w_mw  = gcsd_pkg::sat48(r_t1 - w_quo);
    assign w_mwv = w_mw != '0;
    assign w_jmw = r_in_table && w_mwv && gcsd_pkg::jump_over(w_prev_mw, w_mw, r_mw_thr);

    assign w_div_start = (r_state == ST_DIV);
    assign w_div_den   = (r_op == OP_T1D) ? {r_wdiff, 32'd0}
                                          : 64'({1'b0, r_lam1} + {1'b0, r_lam2});

    always_comb begin
        w_wr.gf    = w_gf;
        w_wr.mw    = w_mw;
        w_wr.we_gf = (r_state == ST_GF) && w_gfv && r_in_table;
        w_wr.we_mw = (r_state == ST_DIVW) && w_div_done && (r_op == OP_T2D)
                     && w_mwv && r_in_table;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_op      <= OP_G1L;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_MUL;
                        r_op    <= OP_G1L;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_op == OP_G2H) begin
                        r_state <= ST_GF;
                    end else if (r_op == OP_T1D || r_op == OP_T2D) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_op    <= t_op'(r_op + 4'd1);
                        r_state <= ST_MUL;
                    end
                end
                ST_GF: begin
                    r_op <= OP_LL;
                    if (r_mw_ok) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_state   <= ST_OUT;
                        r_o_valid <= 1'b1;
                    end
                end
                ST_DIV: begin
                    r_state <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (w_div_done) begin
                        if (r_op == OP_T1D) begin
                            r_op    <= OP_T2A;
                            r_state <= ST_MUL;
                        end else begin
                            r_state   <= ST_OUT;
                            r_o_valid <= 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_o_valid <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_sat      <= w_sat;
                    r_mask     <= w_lli_mask;
                    r_neg1     <= w_ph1[63];
                    r_neg2     <= w_l2[63];
                    r_m1       <= w_ph1[63] ? (~w_ph1 + 64'd1) : w_ph1;
                    r_m2       <= w_l2[63] ? (~w_l2 + 64'd1) : w_l2;
                    r_dneg     <= w_dl[64];
                    r_dmag     <= w_dl[64] ? (~w_dl[63:0] + 64'd1) : w_dl[63:0];
                    r_wneg     <= w_lam2 < w_lam1;
                    r_wdiff    <= (w_lam2 < w_lam1) ? (w_lam1 - w_lam2) : (w_lam2 - w_lam1);
                    r_lam1     <= w_lam1;
                    r_lam2     <= w_lam2;
                    r_p1       <= w_p1;
                    r_p2       <= w_p2;
                    r_in_table <= 32'(w_sat) < 32'(MAX_SATS);
                    r_gf_ok    <= (w_lam1 != '0) && (w_lam2 != '0)
                                  && (w_ph1 != '0) && (w_l2 != '0);
                    r_mw_ok    <= (w_lam1 != '0) && (w_lam2 != '0) && (w_ph1 != '0)
                                  && (w_l2 != '0) && (w_p1 != '0) && (w_p2 != '0)
                                  && (w_lam1 != w_lam2);
                    r_acc      <= '0;
                    r_o_mw     <= '0;
                    r_o_mwv    <= 1'b0;
                end
            end
            ST_ACC: begin
                if (r_op == OP_LL) begin
                    r_ll <= w_prod;
                end else begin
                    r_acc <= n_acc;
                end
            end
            ST_GF: begin
                r_o_gf  <= w_gfv ? w_gf : '0;
                r_o_gfv <= w_gfv;
                if (w_jgf) begin
                    r_mask <= r_mask | w_all[2:0];
                end
                r_acc <= '0;
            end
            ST_DIVW: begin
                if (w_div_done) begin
                    if (r_op == OP_T1D) begin
                        r_t1  <= w_t1s;
                        r_acc <= '0;
                    end else begin
                        r_o_mw  <= w_mwv ? w_mw : '0;
                        r_o_mwv <= w_mwv;
                        if (w_jmw) begin
                            r_mask <= r_mask | w_all[2:0];
                        end
                    end
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gf_thr <= 32'd3277;
            r_mw_thr <= 32'd655360;
            r_nfreq  <= 2'd2;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                gcsd_pkg::REG_GF_THR: r_gf_thr <= pwdata;
                gcsd_pkg::REG_MW_THR: r_mw_thr <= pwdata;
                gcsd_pkg::REG_NFREQ:  r_nfreq  <= pwdata[1:0];
                default:              r_nfreq  <= r_nfreq;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gcsd_pkg::REG_GF_THR: prdata = r_gf_thr;
            gcsd_pkg::REG_MW_THR: prdata = r_mw_thr;
            gcsd_pkg::REG_NFREQ:  prdata = {30'd0, r_nfreq};
            default:              prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    gcsd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    gcsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (w_div_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    gcsd_hist #(
        .MAX_SATS (MAX_SATS),
        .AW       (AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (AW'(r_sat)),
        .i_wr_addr (AW'(r_sat)),
        .i_wr      (w_wr),
        .o_prev_gf (w_prev_gf),
        .o_prev_mw (w_prev_mw),
        .o_ready   (w_hist_ready)
    );

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {5'd0, r_o_mw, r_o_gf, r_mask, r_sat};
    assign m_axis_tuser  = {r_o_mwv, r_o_gfv};
endmodule
`default_nettype wire

// ===== rtl/gcsd_mul.sv =====
// gcsd_mul: shared 32x32 unsigned multiplier with registered product
// no dependencies
`default_nettype none
module gcsd_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== rtl/gcsd_div.sv =====
// gcsd_div: bit-serial restoring divider, 128-bit numerator by 64-bit divisor
// one quotient bit per cycle; no dependencies
`default_nettype none
module gcsd_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [63:0]  i_den,
    output logic [127:0] o_quo,
    output logic         o_done
);
    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [127:0] r_quo;
    logic [63:0]  r_rem;
    logic [63:0]  r_den;
    logic [64:0]  w_rem;
    logic         w_ge;
    logic [64:0]  w_diff;

    assign w_rem  = {r_rem, r_num[127]};
    assign w_ge   = w_rem >= {1'b0, r_den};
    assign w_diff = w_rem - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[126:0], 1'b0};
            r_rem <= w_ge ? w_diff[63:0] : w_rem[63:0];
            r_quo <= {r_quo[126:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule
`default_nettype wire

// ===== rtl/gcsd_hist.sv =====
// gcsd_hist: per-satellite previous gf and mw values, cleared by a sweep after reset
// depends on gcsd_pkg
`default_nettype none
module gcsd_hist #(
    parameter int MAX_SATS = 256,
    parameter int AW       = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [AW-1:0]              i_wr_addr,
    input  gcsd_pkg::t_hist_wr         i_wr,
    output logic [gcsd_pkg::VAL_W-1:0] o_prev_gf,
    output logic [gcsd_pkg::VAL_W-1:0] o_prev_mw,
    output logic                       o_ready
);
    logic [gcsd_pkg::VAL_W-1:0] mem_gf [MAX_SATS];
    logic [gcsd_pkg::VAL_W-1:0] mem_mw [MAX_SATS];
    logic [gcsd_pkg::VAL_W-1:0] r_prev_gf;
    logic [gcsd_pkg::VAL_W-1:0] r_prev_mw;
    logic                       r_clearing;
    logic [AW-1:0]              r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_SATS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem_gf[r_clr_addr] <= '0;
            mem_mw[r_clr_addr] <= '0;
        end else begin
            if (i_wr.we_gf) begin
                mem_gf[i_wr_addr] <= i_wr.gf;
            end
            if (i_wr.we_mw) begin
                mem_mw[i_wr_addr] <= i_wr.mw;
            end
        end
        r_prev_gf <= mem_gf[i_rd_addr];
        r_prev_mw <= mem_mw[i_rd_addr];
    end

    assign o_prev_gf = r_prev_gf;
    assign o_prev_mw = r_prev_mw;
    assign o_ready   = !r_clearing;
endmodule
`default_nettype wire

// ===== rtl/gcsd_chk.sv =====
// gcsd_chk: port-level checks of the detector top level, bound to it below
// depends on gnss_cycle_slip_detector_unit
`default_nettype none
module gcsd_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    // history sweep holds off input right after reset
    a_rst_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // one observation at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready after a transaction");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // a value not formed reads as zero
    a_gf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[58:11] == '0)
        else $error("gf value nonzero without gf_valid");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");
endmodule

bind gnss_cycle_slip_detector_unit gcsd_chk u_gcsd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== dv/tb_gnss_cycle_slip_detector_unit.sv =====
// tb_gnss_cycle_slip_detector_unit: self-checking testbench for the gnss cycle slip detector
// depends on gcsd_pkg and gnss_cycle_slip_detector_unit; drives apb config and axi-stream data
`default_nettype none
module tb_gnss_cycle_slip_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SATS = 256;

    // one observation as it enters the block
    typedef struct {
        logic [7:0]  sat;
        logic [5:0]  lli;
        logic [63:0] ph1;
        logic [63:0] ph2;
        logic [63:0] ph3;
        logic [47:0] rng1;
        logic [47:0] rng2;
        logic [31:0] lam1;
        logic [31:0] lam2;
        logic        sel_f3;
    } obs_t;

    // one slip report as it leaves the block
    typedef struct packed {
        logic [7:0]  sat;
        logic [2:0]  mask;
        logic [47:0] gf;
        logic        gf_ok;
        logic [47:0] mw;
        logic        mw_ok;
    } slip_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [367:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    gnss_cycle_slip_detector_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state: thresholds, frequency count and per-satellite history
    logic [31:0] gf_thr;
    logic [31:0] mw_thr;
    logic [1:0]  nfreq;
    logic [47:0] gf_hist [NUM_SATS];
    logic [47:0] mw_hist [NUM_SATS];

    slip_t       slip_q[$];     // predicted reports, oldest first
    int          mismatches;
    int          obs_sent;
    int          slips_seen;
    bit          rx_busy;       // receiver inserts random stalls when set
    bit          tx_busy;       // sender inserts random gaps when set
    int          rx_hold;       // long receiver hold-off, counted down by the receiver
    int          rx_wait;       // stall drawn after each report
    obs_t        last_obs [8];  // recent observation per tracked satellite
    bit          have_last [8];

    // clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #50ms;
        $display("timeout after %0d observations", obs_sent);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // arithmetic predictor
    // ---------------------------------------------------------------

    // clamp to 48 bits signed
    function automatic logic [47:0] clamp48(input logic [127:0] v);
        if (v[127:47] == {81{v[127]}}) return v[47:0];
        return v[127] ? gcsd_pkg::MIN48 : gcsd_pkg::MAX48;
    endfunction

    // jump test: previous value present and |now - prev| above threshold
    function automatic bit over_thr(input logic [47:0] prev, input logic [47:0] now,
                                    input logic [31:0] thr);
        logic [48:0] d;
        logic [48:0] a;
        d = {now[47], now} - {prev[47], prev};
        a = d[48] ? -d : d;
        return (prev != '0) && (a > {17'd0, thr});
    endfunction

    // work out the report for one accepted observation and update the history
    function automatic slip_t slip_of(input obs_t o);
        slip_t              r;
        logic [63:0]        l2;
        logic [2:0]         all_in_use;
        logic signed [127:0] a1;
        logic signed [127:0] a2;
        logic signed [127:0] d;
        logic [64:0]        dl;
        logic [63:0]        dmag;
        logic               dneg;
        logic               wneg;
        logic [31:0]        wdiff;
        logic [127:0]       t1;
        logic [127:0]       t2;
        logic [127:0]       p1;
        logic [127:0]       p2;
        r = '{sat: o.sat, mask: 3'd0, gf: '0, gf_ok: 1'b0, mw: '0, mw_ok: 1'b0};
        l2 = o.sel_f3 ? o.ph3 : o.ph2;
        all_in_use = 3'((4'd1 << nfreq) - 4'd1);

        // loss-of-lock per frequency in use, only where phase is present
        if (nfreq > 0 && o.ph1 != 0 && o.lli[1:0] != 0) r.mask[0] = 1'b1;
        if (nfreq > 1 && o.ph2 != 0 && o.lli[3:2] != 0) r.mask[1] = 1'b1;
        if (nfreq > 2 && o.ph3 != 0 && o.lli[5:4] != 0) r.mask[2] = 1'b1;

        if (o.lam1 != 0 && o.lam2 != 0 && o.ph1 != 0 && l2 != 0) begin
            // geometry-free: lam1*L1 - lam2*L2, floored to Q.16
            a1 = $signed({96'd0, o.lam1}) * $signed({{64{o.ph1[63]}}, o.ph1});
            a2 = $signed({96'd0, o.lam2}) * $signed({{64{l2[63]}}, l2});
            d = a1 - a2;
            r.gf = clamp48(128'(d >>> 32));
            r.gf_ok = (r.gf != '0);
            if (!r.gf_ok) r.gf = '0;

            // melbourne-wubbena: wide-lane phase minus narrow-lane range
            if (o.rng1 != 0 && o.rng2 != 0 && o.lam1 != o.lam2) begin
                dl = {o.ph1[63], o.ph1} - {l2[63], l2};
                dneg = dl[64];
                dmag = dneg ? 64'(-dl) : dl[63:0];
                wneg = o.lam2 < o.lam1;
                wdiff = wneg ? o.lam1 - o.lam2 : o.lam2 - o.lam1;
                t1 = (128'(o.lam1) * 128'(o.lam2) * 128'(dmag)) / {64'd0, wdiff, 32'd0};
                p1 = 128'(o.lam2) * 128'(o.rng1);
                p2 = 128'(o.lam1) * 128'(o.rng2);
                t2 = (p1 + p2) / (128'(o.lam1) + 128'(o.lam2));
                if (dneg != wneg) t1 = -t1;
                r.mw = clamp48(t1 - t2);
                r.mw_ok = (r.mw != '0);
            end
        end

        // history compare and update
        if (r.gf_ok) begin
            if (over_thr(gf_hist[o.sat], r.gf, gf_thr)) r.mask |= all_in_use;
            gf_hist[o.sat] = r.gf;
        end
        if (r.mw_ok) begin
            if (over_thr(mw_hist[o.sat], r.mw, mw_thr)) r.mask |= all_in_use;
            mw_hist[o.sat] = r.mw;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // bus drivers
    // ---------------------------------------------------------------

    // offer one observation; returns once the block has taken it
    task automatic send_obs(input obs_t o);
        int gap;
        gap = tx_busy ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, o.lam2, o.lam1, o.rng2, o.rng1, o.ph3, o.ph2, o.ph1,
                          o.lli, o.sat};
        s_axis_tuser  <= o.sel_f3;
        do @(posedge i_clk); while (!s_axis_tready);
        slip_q.push_back(slip_of(o));
        obs_sent++;
    endtask

    // drop valid and wait until every predicted report has come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (slip_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // apb write, setup then access; only done with the block idle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gcsd_pkg::REG_GF_THR: gf_thr = val;
            gcsd_pkg::REG_MW_THR: mw_thr = val;
            gcsd_pkg::REG_NFREQ:  nfreq  = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] gt, input logic [31:0] mt,
                              input logic [1:0] nf);
        reg_write(gcsd_pkg::REG_GF_THR, gt);
        reg_write(gcsd_pkg::REG_MW_THR, mt);
        reg_write(gcsd_pkg::REG_NFREQ, {30'd0, nf});
    endtask

    // receiver: long hold-off first, then per-report random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_wait > 0) begin
            m_axis_tready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // report checker, compares each transaction with the oldest prediction
    always @(posedge i_clk) begin
        slip_t got;
        slip_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.sat   = m_axis_tdata[7:0];
            got.mask  = m_axis_tdata[10:8];
            got.gf    = m_axis_tdata[58:11];
            got.mw    = m_axis_tdata[106:59];
            got.gf_ok = m_axis_tuser[0];
            got.mw_ok = m_axis_tuser[1];
            rx_wait = rx_busy ? $urandom_range(0, 8) : 0;
            if (slip_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: sat %0d mask %b", got.sat, got.mask);
            end else begin
                want = slip_q.pop_front();
                if (got.mask != 0) slips_seen++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"report mismatch: expected sat %0d mask %b gf %h/%b mw %h/%b,",
                                  " got sat %0d mask %b gf %h/%b mw %h/%b"},
                                 want.sat, want.mask, want.gf, want.gf_ok, want.mw, want.mw_ok,
                                 got.sat, got.mask, got.gf, got.gf_ok, got.mw, got.mw_ok);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] small_step();
        // signed small phase step, occasionally a whole-cycle jump
        if ($urandom_range(0, 9) == 0) return 64'(signed'($urandom_range(0, 40)) - 20) <<< 16;
        return 64'(signed'($urandom_range(0, 400)) - 200);
    endfunction

    // plausible observation: real-looking wavelengths, phases and ranges
    function automatic obs_t plausible(input logic [7:0] sat);
        obs_t o;
        o.sat    = sat;
        o.lli    = ($urandom_range(0, 7) == 0) ? 6'($urandom()) : 6'd0;
        o.ph1    = 64'(signed'($urandom())) <<< $urandom_range(8, 28);
        o.ph2    = 64'(signed'($urandom())) <<< $urandom_range(8, 28);
        o.ph3    = 64'(signed'($urandom())) <<< $urandom_range(8, 28);
        o.rng1   = 48'({$urandom_range(0, 1024), $urandom()}) + 48'h1_0000_0000;
        o.rng2   = o.rng1 + 48'($urandom_range(0, 65535));
        o.lam1   = 32'd816043786 + $urandom_range(0, 4096);
        o.lam2   = 32'd1047856000 + $urandom_range(0, 4096);
        o.sel_f3 = 1'($urandom_range(0, 1));
        return o;
    endfunction

    // fully random observation, some fields zeroed
    function automatic obs_t noise_obs();
        obs_t o;
        o.sat    = 8'($urandom());
        o.lli    = 6'($urandom());
        o.ph1    = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
        o.ph2    = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
        o.ph3    = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
        o.rng1   = ($urandom_range(0, 7) == 0) ? 48'd0 : 48'(rand64());
        o.rng2   = ($urandom_range(0, 7) == 0) ? 48'd0 : 48'(rand64());
        o.lam1   = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
        o.lam2   = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
        if ($urandom_range(0, 15) == 0) o.lam2 = o.lam1;
        o.sel_f3 = 1'($urandom_range(0, 1));
        return o;
    endfunction

    // mostly continued tracks of a few satellites, the rest noise
    task automatic send_mixed(input int count);
        obs_t o;
        int   k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 7);
            if ($urandom_range(0, 4) == 0) begin
                o = noise_obs();
            end else if (have_last[k] && $urandom_range(0, 9) != 0) begin
                o = last_obs[k];
                o.ph1  += small_step();
                o.ph2  += small_step();
                o.ph3  += small_step();
                o.rng1 += 48'($urandom_range(0, 1 << 18));
                o.rng2 += 48'($urandom_range(0, 1 << 18));
                o.lli   = ($urandom_range(0, 15) == 0) ? 6'($urandom()) : 6'd0;
            end else begin
                o = plausible(8'(k * 31 + 1));
            end
            if (o.sat == 8'(k * 31 + 1)) begin
                last_obs[k]  = o;
                have_last[k] = 1'b1;
            end
            send_obs(o);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // field extremes and each special case, at reset settings
    task automatic test_directed();
        obs_t o;
        o = '{sat: 8'd0, lli: 6'd0, ph1: '0, ph2: '0, ph3: '0, rng1: '0, rng2: '0,
              lam1: '0, lam2: '0, sel_f3: 1'b0};
        send_obs(o);                                   // everything missing
        o.lli = 6'h3F;
        send_obs(o);                                   // lock loss without phase
        o = plausible(8'd5);
        o.lli = 6'h3F;
        send_obs(o);                                   // lock loss on all frequencies
        o.lli = 6'h00;
        send_obs(o);                                   // same again: no jump
        o.ph1 += 64'h0010_0000;
        send_obs(o);                                   // geometry-free jump
        o.rng1 += 48'h0100_0000_0000;
        send_obs(o);                                   // wide-lane jump
        o.sel_f3 = 1'b1;
        send_obs(o);                                   // third frequency as second
        o.ph3 = '0;
        send_obs(o);                                   // second phase missing
        o = plausible(8'd6);
        o.lam1 = '0;
        send_obs(o);                                   // wavelength unknown
        o = plausible(8'd6);
        o.rng2 = '0;
        send_obs(o);                                   // range missing: geometry-free only
        o = plausible(8'd7);
        o.lam2 = o.lam1;
        o.ph2 = o.ph1;
        o.sel_f3 = 1'b0;
        send_obs(o);                                   // equal wavelengths, zero combination
        o = plausible(8'd8);
        o.lam1 = 32'h8000_0000;
        o.lam2 = 32'h4000_0000;
        o.ph1 = 64'd2;
        o.ph2 = 64'd12;
        o.rng1 = 48'd5;
        o.rng2 = 48'd5;
        o.sel_f3 = 1'b0;
        send_obs(o);                                   // wide-lane exactly zero
        o = '{sat: 8'hFF, lli: 6'h2A, ph1: 64'h7FFF_FFFF_FFFF_FFFF,
              ph2: 64'h8000_0000_0000_0000, ph3: 64'h8000_0000_0000_0000,
              rng1: 48'hFFFF_FFFF_FFFF, rng2: 48'hFFFF_FFFF_FFFF,
              lam1: 32'hFFFF_FFFF, lam2: 32'h0000_0001, sel_f3: 1'b0};
        send_obs(o);                                   // positive saturation
        o.ph1 = 64'h8000_0000_0000_0000;
        o.ph2 = 64'h7FFF_FFFF_FFFF_FFFF;
        o.lli = 6'h15;
        send_obs(o);                                   // negative saturation
        o.lam1 = 32'h0000_0001;
        o.lam2 = 32'hFFFF_FFFF;
        o.sel_f3 = 1'b1;
        send_obs(o);
        o.ph1 = 64'hFFFF_FFFF_FFFF_FFFF;
        o.ph3 = 64'h0000_0000_0000_0001;
        o.rng1 = 48'd1;
        o.rng2 = 48'd1;
        send_obs(o);
        drain();
    endtask

    // register extremes and the unused-frequency setting
    task automatic test_config_extremes();
        set_config(32'd0, 32'd0, 2'd3);
        send_mixed(60);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1);
        send_mixed(60);
        set_config(32'd0, 32'hFFFF_FFFF, 2'd0);
        send_mixed(60);
        set_config(32'd3277, 32'd655360, 2'd2);
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_back_pressure();
        drain();
        rx_hold = 600;
        send_mixed(8);
        drain();                                       // sender pauses until all reports are in
        send_mixed(20);
    endtask

    // bulk random observations across several settings
    task automatic test_random_tracks();
        for (int phase = 0; phase < 6; phase++) begin
            set_config($urandom_range(0, 1) ? $urandom_range(0, 1 << 17) : $urandom(),
                       $urandom_range(0, 1) ? $urandom_range(0, 1 << 22) : $urandom(),
                       2'($urandom_range(0, 3)));
            rx_busy = (phase != 2);
            tx_busy = (phase != 3);
            send_mixed(290);
        end
        rx_busy = 1'b1;
        tx_busy = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        obs_sent      = 0;
        slips_seen    = 0;
        rx_busy       = 1'b1;
        tx_busy       = 1'b1;
        rx_hold       = 0;
        rx_wait       = 0;
        gf_thr        = 32'd3277;
        mw_thr        = 32'd655360;
        nfreq         = 2'd2;
        for (int s = 0; s < NUM_SATS; s++) begin
            gf_hist[s] = '0;
            mw_hist[s] = '0;
        end
        for (int k = 0; k < 8; k++) have_last[k] = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_back_pressure();
        test_random_tracks();
        drain();
        repeat (400) @(posedge i_clk);

        $display("sent %0d observations over several threshold and frequency settings,",
                 obs_sent);
        $display("%0d reports carried slip flags, %0d mismatches", slips_seen, mismatches);
        if (mismatches == 0 && slip_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== gnss_cycle_slip_detector_unit.f =====
rtl/gcsd_pkg.sv
rtl/gcsd_mul.sv
rtl/gcsd_div.sv
rtl/gcsd_hist.sv
rtl/gnss_cycle_slip_detector_unit.sv
rtl/gcsd_chk.sv
dv/tb_gnss_cycle_slip_detector_unit.sv
